### rtl/psq_pkg.sv
`timescale 1ns / 1ps

package psq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_W            = 32;
  localparam int COOKIE_W        = 32;
  localparam int LEVEL_W         = 4;
  localparam int STATUS_W        = 3;

  localparam logic KIND_STORE    = 1'b0;
  localparam logic KIND_RETRIEVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_STORED    = 3'd0,
    STATUS_DUPLICATE = 3'd1,
    STATUS_OVERFLOW  = 3'd2,
    STATUS_SERVED    = 3'd3,
    STATUS_NONE      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic update;
  } ctrl_t;

endpackage

### rtl/psq_ctrl.sv
`timescale 1ns / 1ps

module psq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output psq_pkg::ctrl_t ctrl
);

  psq_pkg::state_t state_r, state_nxt;
  logic            accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psq_pkg::ST_IDLE: begin
        if (start) state_nxt = psq_pkg::ST_COMPARE;
      end
      psq_pkg::ST_COMPARE: begin
        state_nxt = psq_pkg::ST_UPDATE;
      end
      psq_pkg::ST_UPDATE: begin
        state_nxt = start ? psq_pkg::ST_COMPARE : psq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = psq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy         = 1'b0;
    ctrl.compare = 1'b0;
    ctrl.update  = 1'b0;
    unique case (state_r)
      psq_pkg::ST_IDLE: begin
      end
      psq_pkg::ST_COMPARE: begin
        busy         = 1'b1;
        ctrl.compare = 1'b1;
      end
      psq_pkg::ST_UPDATE: begin
        ctrl.update = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
    ctrl.capture = start && !busy;
  end

  // compare lasts exactly one cycle and is always followed by update
  a_compare_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.compare |=> ctrl.update)
    else $error("compare not followed by update");

  a_accept_to_compare: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ctrl.compare)
    else $error("accepted item did not enter compare");

endmodule

### rtl/psq_datapath.sv
`timescale 1ns / 1ps

module psq_datapath #(
  parameter int QUEUE_DEPTH = psq_pkg::QUEUE_DEPTH_DEF,
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  psq_pkg::ctrl_t                 ctrl,
  input  logic                           in_kind,
  input  logic [psq_pkg::ID_W-1:0]       in_requester_id,
  input  logic [psq_pkg::COOKIE_W-1:0]   in_cookie,
  input  logic [psq_pkg::LEVEL_W-1:0]    in_level,
  output logic                           out_valid,
  output logic [psq_pkg::STATUS_W-1:0]   out_status,
  output logic [psq_pkg::ID_W-1:0]       out_served_id,
  output logic [psq_pkg::COOKIE_W-1:0]   out_served_cookie,
  output logic                           out_zero_level_warning,
  output logic                           out_waiters_remain,
  output logic [CNT_W-1:0]               out_queue_length,
  output logic [CNT_W-1:0]               out_high_water
);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  // captured item
  logic                         kind_r;
  logic [psq_pkg::ID_W-1:0]     id_r;
  logic [psq_pkg::COOKIE_W-1:0] cookie_r;
  logic [psq_pkg::LEVEL_W-1:0]  level_r;

  // compare results
  logic                   dup_r, dup_nxt;
  logic [QUEUE_DEPTH-1:0] elig_r, elig_nxt;

  // entry storage, kept compacted in arrival order
  logic [psq_pkg::ID_W-1:0]     ids_r     [QUEUE_DEPTH];
  logic [psq_pkg::COOKIE_W-1:0] cookies_r [QUEUE_DEPTH];
  logic [psq_pkg::LEVEL_W-1:0]  levels_r  [QUEUE_DEPTH];
  logic [psq_pkg::ID_W-1:0]     ids_nxt     [QUEUE_DEPTH];
  logic [psq_pkg::COOKIE_W-1:0] cookies_nxt [QUEUE_DEPTH];
  logic [psq_pkg::LEVEL_W-1:0]  levels_nxt  [QUEUE_DEPTH];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] peak_r, peak_nxt;

  // result register
  logic                         out_valid_r;
  psq_pkg::status_t             status_r, status_nxt;
  logic [psq_pkg::ID_W-1:0]     sid_r, sid_nxt;
  logic [psq_pkg::COOKIE_W-1:0] sck_r, sck_nxt;
  logic                         warn_r, warn_nxt;
  logic                         remain_r;
  logic [CNT_W-1:0]             qlen_r;
  logic [CNT_W-1:0]             hw_r;

  logic [QUEUE_DEPTH-1:0] neg_elig;
  logic [QUEUE_DEPTH-1:0] from_hit;
  logic [QUEUE_DEPTH-1:0] first_hit;
  logic                   hit;
  logic                   do_store;
  logic                   do_remove;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      kind_r   <= in_kind;
      id_r     <= in_requester_id;
      cookie_r <= in_cookie;
      level_r  <= in_level;
    end
  end

  // parallel compare against every queued entry
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      elig_nxt[i] = (CNT_W'(i) < count_r) && (levels_r[i] >= level_r);
    end
    dup_nxt = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      dup_nxt = dup_nxt | ((CNT_W'(i) < count_r) && (ids_r[i] == id_r));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      dup_r  <= dup_nxt;
      elig_r <= elig_nxt;
    end
  end

  // oldest eligible entry and everything at or after it
  assign neg_elig  = ~elig_r + QUEUE_DEPTH'(1);
  assign from_hit  = elig_r | neg_elig;
  assign first_hit = elig_r & neg_elig;
  assign hit       = |elig_r;

  always_comb begin
    do_store   = 1'b0;
    do_remove  = 1'b0;
    warn_nxt   = 1'b0;
    sid_nxt    = '0;
    sck_nxt    = '0;
    count_nxt  = count_r;
    status_nxt = psq_pkg::STATUS_NONE;
    if (kind_r == psq_pkg::KIND_STORE) begin
      priority if (dup_r) begin
        status_nxt = psq_pkg::STATUS_DUPLICATE;
      end else if (count_r >= DEPTH_CNT) begin
        status_nxt = psq_pkg::STATUS_OVERFLOW;
      end else begin
        status_nxt = psq_pkg::STATUS_STORED;
        do_store   = 1'b1;
        warn_nxt   = (level_r == '0);
        count_nxt  = count_r + CNT_W'(1);
      end
    end else begin
      if (hit) begin
        status_nxt = psq_pkg::STATUS_SERVED;
        do_remove  = 1'b1;
        count_nxt  = count_r - CNT_W'(1);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          sid_nxt = sid_nxt | (ids_r[i] & {psq_pkg::ID_W{first_hit[i]}});
          sck_nxt = sck_nxt | (cookies_r[i] & {psq_pkg::COOKIE_W{first_hit[i]}});
        end
      end
    end
    peak_nxt = (count_nxt > peak_r) ? count_nxt : peak_r;
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ids_nxt[i]     = ids_r[i];
      cookies_nxt[i] = cookies_r[i];
      levels_nxt[i]  = levels_r[i];
      if (do_store && (CNT_W'(i) == count_r)) begin
        ids_nxt[i]     = id_r;
        cookies_nxt[i] = cookie_r;
        levels_nxt[i]  = level_r;
      end
    end
    // close the gap left by the removed entry
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      if (do_remove && from_hit[i]) begin
        ids_nxt[i]     = ids_r[i+1];
        cookies_nxt[i] = cookies_r[i+1];
        levels_nxt[i]  = levels_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        ids_r[i]     <= ids_nxt[i];
        cookies_r[i] <= cookies_nxt[i];
        levels_r[i]  <= levels_nxt[i];
      end
      status_r <= status_nxt;
      sid_r    <= sid_nxt;
      sck_r    <= sck_nxt;
      warn_r   <= warn_nxt;
      remain_r <= (count_nxt != '0);
      qlen_r   <= count_nxt;
      hw_r     <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.update;
      if (ctrl.update) begin
        count_r <= count_nxt;
        peak_r  <= peak_nxt;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = status_r;
  assign out_served_id          = sid_r;
  assign out_served_cookie      = sck_r;
  assign out_zero_level_warning = warn_r;
  assign out_waiters_remain     = remain_r;
  assign out_queue_length       = qlen_r;
  assign out_high_water         = hw_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("entry count beyond depth");

  a_peak_covers_count: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= count_r)
    else $error("high-water mark below entry count");

  a_served_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != psq_pkg::STATUS_SERVED) |->
      (sid_r == '0 && sck_r == '0))
    else $error("served fields set on a non-served result");

  a_length_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (qlen_r == count_r && remain_r == (count_r != '0)))
    else $error("reported length disagrees with entry count");

endmodule

### rtl/priority_screened_wait_queue_top.sv
`timescale 1ns / 1ps
// channel   handshake              fields
// -------   ---------------------  --------------------------------------------
// in        start / busy           in_kind in_requester_id in_cookie in_level
// out       out_valid (strobe)     out_status out_served_id out_served_cookie
//                                  out_zero_level_warning out_waiters_remain
//                                  out_queue_length out_high_water
//
// an item is taken when start is high and busy is low; busy is high for one
// cycle (the parallel compare over all entries), and a new item may be taken
// during the following update cycle, while the previous item is written back
// the result strobes out_valid for one cycle, from the result register loaded
// in update; the receiver cannot stall; synchronous active-low reset empties
// the queue and clears the high-water mark, no clearing pass is needed

module priority_screened_wait_queue_top #(
  parameter int QUEUE_DEPTH = psq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_kind,
  input  logic [psq_pkg::ID_W-1:0]             in_requester_id,
  input  logic [psq_pkg::COOKIE_W-1:0]         in_cookie,
  input  logic [psq_pkg::LEVEL_W-1:0]          in_level,
  output logic                                 out_valid,
  output logic [psq_pkg::STATUS_W-1:0]         out_status,
  output logic [psq_pkg::ID_W-1:0]             out_served_id,
  output logic [psq_pkg::COOKIE_W-1:0]         out_served_cookie,
  output logic                                 out_zero_level_warning,
  output logic                                 out_waiters_remain,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     out_queue_length,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     out_high_water
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  psq_pkg::ctrl_t ctrl;

  psq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  psq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CNT_W       (CNT_W)
  ) u_datapath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .ctrl                   (ctrl),
    .in_kind                (in_kind),
    .in_requester_id        (in_requester_id),
    .in_cookie              (in_cookie),
    .in_level               (in_level),
    .out_valid              (out_valid),
    .out_status             (out_status),
    .out_served_id          (out_served_id),
    .out_served_cookie      (out_served_cookie),
    .out_zero_level_warning (out_zero_level_warning),
    .out_waiters_remain     (out_waiters_remain),
    .out_queue_length       (out_queue_length),
    .out_high_water         (out_high_water)
  );

endmodule

### test/priority_screened_wait_queue_top_test.sv
`timescale 1ns / 1ps

module priority_screened_wait_queue_top_test;

  localparam int WAIT_DEPTH = psq_pkg::QUEUE_DEPTH_DEF;
  localparam int LEN_W = $clog2(WAIT_DEPTH + 1);
  localparam int RANDOM_ITEMS = 1525;
  localparam int ID_POOL = 24;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic                         kind;
    logic [psq_pkg::ID_W-1:0]     id;
    logic [psq_pkg::COOKIE_W-1:0] cookie;
    logic [psq_pkg::LEVEL_W-1:0]  level;
  } waiter_req_t;

  typedef struct {
    psq_pkg::status_t             status;
    logic [psq_pkg::ID_W-1:0]     id;
    logic [psq_pkg::COOKIE_W-1:0] cookie;
    logic                         warn;
    logic                         remain;
    logic [LEN_W-1:0]             len;
    logic [LEN_W-1:0]             hw;
  } wait_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         in_kind = psq_pkg::KIND_STORE;
  logic [psq_pkg::ID_W-1:0]     in_requester_id = '0;
  logic [psq_pkg::COOKIE_W-1:0] in_cookie = '0;
  logic [psq_pkg::LEVEL_W-1:0]  in_level = '0;
  logic                         out_valid;
  logic [psq_pkg::STATUS_W-1:0] out_status;
  logic [psq_pkg::ID_W-1:0]     out_served_id;
  logic [psq_pkg::COOKIE_W-1:0] out_served_cookie;
  logic                         out_zero_level_warning;
  logic                         out_waiters_remain;
  logic [LEN_W-1:0]             out_queue_length;
  logic [LEN_W-1:0]             out_high_water;

  waiter_req_t                  pending_reqs[$];
  wait_result_t                 pending_results[$];
  logic [psq_pkg::ID_W-1:0]     queued_ids[$];
  logic [psq_pkg::COOKIE_W-1:0] queued_cookies[$];
  logic [psq_pkg::LEVEL_W-1:0]  queued_levels[$];
  int unsigned                  peak_len = 0;
  int unsigned                  fail_count = 0;
  int unsigned                  items_sent = 0;
  int unsigned                  results_seen = 0;
  int unsigned                  gap_left = 0;
  int unsigned                  cycles = 0;
  waiter_req_t                  cur_req;

  priority_screened_wait_queue_top #(
    .QUEUE_DEPTH(WAIT_DEPTH)
  ) u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_kind                (in_kind),
    .in_requester_id        (in_requester_id),
    .in_cookie              (in_cookie),
    .in_level               (in_level),
    .out_valid              (out_valid),
    .out_status             (out_status),
    .out_served_id          (out_served_id),
    .out_served_cookie      (out_served_cookie),
    .out_zero_level_warning (out_zero_level_warning),
    .out_waiters_remain     (out_waiters_remain),
    .out_queue_length       (out_queue_length),
    .out_high_water         (out_high_water)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic wait_result_t predict_wait_queue(waiter_req_t req);
    wait_result_t r;
    bit           dup;
    int           hit;
    r.status = psq_pkg::STATUS_NONE;
    r.id     = '0;
    r.cookie = '0;
    r.warn   = 1'b0;
    if (req.kind == psq_pkg::KIND_STORE) begin
      dup = 1'b0;
      foreach (queued_ids[i]) if (queued_ids[i] == req.id) dup = 1'b1;
      if (dup) begin
        r.status = psq_pkg::STATUS_DUPLICATE;
      end else if (queued_ids.size() >= WAIT_DEPTH) begin
        r.status = psq_pkg::STATUS_OVERFLOW;
      end else begin
        queued_ids.push_back(req.id);
        queued_cookies.push_back(req.cookie);
        queued_levels.push_back(req.level);
        if (queued_ids.size() > peak_len) peak_len = queued_ids.size();
        r.warn   = (req.level == '0);
        r.status = psq_pkg::STATUS_STORED;
      end
    end else begin
      hit = -1;
      foreach (queued_levels[i]) if (hit < 0 && queued_levels[i] >= req.level) hit = i;
      if (hit >= 0) begin
        r.id     = queued_ids[hit];
        r.cookie = queued_cookies[hit];
        queued_ids.delete(hit);
        queued_cookies.delete(hit);
        queued_levels.delete(hit);
        r.status = psq_pkg::STATUS_SERVED;
      end
    end
    r.remain = (queued_ids.size() != 0);
    r.len    = LEN_W'(queued_ids.size());
    r.hw     = LEN_W'(peak_len);
    return r;
  endfunction

  task automatic push_req(logic kind, logic [psq_pkg::ID_W-1:0] id,
                          logic [psq_pkg::COOKIE_W-1:0] cookie,
                          logic [psq_pkg::LEVEL_W-1:0] level);
    waiter_req_t req;
    req.kind   = kind;
    req.id     = id;
    req.cookie = cookie;
    req.level  = level;
    pending_reqs.push_back(req);
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // driver
  always @(posedge clk) begin
    logic next_start;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        pending_results.push_back(predict_wait_queue(cur_req));
        items_sent++;
        next_start = 1'b0;
        // every fourth stretch of 64 items runs back to back
        if ((items_sent / 64) % 4 == 0) gap_left = 0;
        else gap_left = $urandom_range(18, 0);
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          in_kind         <= cur_req.kind;
          in_requester_id <= cur_req.id;
          in_cookie       <= cur_req.cookie;
          in_level        <= cur_req.level;
          next_start = 1'b1;
        end
      end
      start <= next_start;
    end
  end

  // monitor
  always @(posedge clk) begin
    wait_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(out_status), 32'(want.status));
        check_field("served_id", out_served_id, want.id);
        check_field("served_cookie", out_served_cookie, want.cookie);
        check_field("zero_level_warning", 32'(out_zero_level_warning), 32'(want.warn));
        check_field("waiters_remain", 32'(out_waiters_remain), 32'(want.remain));
        check_field("queue_length", 32'(out_queue_length), 32'(want.len));
        check_field("high_water", 32'(out_high_water), 32'(want.hw));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [psq_pkg::ID_W-1:0] id_pool[ID_POOL];
    logic [psq_pkg::ID_W-1:0] id;
    int unsigned              store_pct;

    // empty queue, extremes, zero level, duplicate, threshold screening
    push_req(psq_pkg::KIND_STORE, 32'h0000_0000, 32'h0000_0000, 4'd0);
    push_req(psq_pkg::KIND_STORE, 32'hffff_ffff, 32'hffff_ffff, 4'd15);
    push_req(psq_pkg::KIND_STORE, 32'h0000_0000, 32'h1234_5678, 4'd9);
    push_req(psq_pkg::KIND_RETRIEVE, $urandom, $urandom, 4'd15);
    push_req(psq_pkg::KIND_RETRIEVE, $urandom, $urandom, 4'd1);
    push_req(psq_pkg::KIND_RETRIEVE, 32'hffff_ffff, 32'hffff_ffff, 4'd0);
    push_req(psq_pkg::KIND_RETRIEVE, $urandom, $urandom, 4'd0);
    // fill to full, then overflow and duplicate on a full queue
    for (int i = 1; i <= WAIT_DEPTH; i++) begin
      push_req(psq_pkg::KIND_STORE, psq_pkg::ID_W'(i), $urandom, psq_pkg::LEVEL_W'(i));
    end
    push_req(psq_pkg::KIND_STORE, 32'h8000_0000, $urandom, 4'd7);
    push_req(psq_pkg::KIND_STORE, 32'd5, $urandom, 4'd3);
    // removal from the middle
    push_req(psq_pkg::KIND_RETRIEVE, $urandom, $urandom, 4'd8);

    foreach (id_pool[i]) id_pool[i] = $urandom;
    id_pool[0] = '0;
    id_pool[1] = '1;
    store_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) store_pct = $urandom_range(85, 20);
      if ($urandom_range(99) < store_pct) begin
        id = ($urandom_range(99) < 65) ? id_pool[$urandom_range(ID_POOL - 1)] : $urandom;
        push_req(psq_pkg::KIND_STORE, id, $urandom, psq_pkg::LEVEL_W'($urandom_range(15)));
      end else begin
        push_req(psq_pkg::KIND_RETRIEVE, $urandom, $urandom,
                 ($urandom_range(3) == 0) ? 4'd0 : psq_pkg::LEVEL_W'($urandom_range(15)));
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || start || pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
